// ===== rtl/core/leaky_integrator_cascade_macros.svh =====
// assertion helpers shared by the cascade modules
// each expects clk and rst_n in the scope where it is used
`ifndef LEAKY_INTEGRATOR_CASCADE_MACROS_SVH
`define LEAKY_INTEGRATOR_CASCADE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lic_pkg.sv =====
package lic_pkg;

    localparam int STAGES_DEFAULT = 16;
    localparam int MAX_REPORT     = 16;

    localparam logic [4:0] CFG_STAGES_RESET = 5'd16;

    // action codes of the input word
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] sample;
        logic [3:0]         coef_stage;
        logic [15:0]        coef_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         stage_index;
        logic signed [23:0] stage_value;
        logic               last;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_LOAD,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [15:0] sample;
        logic [3:0]         coef_stage;
        logic [15:0]        coef_value;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

// ===== rtl/core/leaky_integrator_cascade.sv =====
// cascade of first-order leaky integrators with a shared multiply-accumulate
// in_valid/in_stall/in_word: one word per command; action sample runs the
//   chain, action load writes one decay coefficient, action clear zeroes
//   every stage value; unused action codes are taken and dropped
// out_valid/out_stall/out_word: one word per stage in use, stage 0 first,
//   last set on the final one; a stalled word holds until taken
// cfg_valid/cfg_ready/cfg_data: number of stages in use, always ready;
//   zero acts as one, values above min(STAGES, 16) are clamped
// a two-word command queue parts the input from the arithmetic, so input is
//   taken while the back end is busy or the output is stalled
// steps: each stage passes through the one multiplier as read, multiply and
//   write back, stage 0 first; load and clear are done by the back end in
//   its idle state as it takes the command from the queue
// output stall freezes the write-back step, holding the whole chain
// reset: stage values and coefficients read as zero (pass-through), stages
//   in use is 16, queue empty, no output word pending
module leaky_integrator_cascade #(
    parameter int STAGES = lic_pkg::STAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lic_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output lic_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    lic_pkg::head_t head;
    logic           pop;

    // config writes land in a single register, never blocked
    assign cfg_ready = 1'b1;

    // front: decode and queue commands
    lic_front #(
        .STAGES (STAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .head     (head),
        .pop      (pop)
    );

    // back: stage memories, multiplier and output register
    lic_back #(
        .STAGES (STAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// ===== rtl/core/lic_front.sv =====
`include "leaky_integrator_cascade_macros.svh"

module lic_front #(
    parameter int STAGES = lic_pkg::STAGES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lic_pkg::in_word_t in_word,
    output lic_pkg::head_t    head,
    input  logic              pop
);

    logic [1:0]    cnt_reg;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    lic_pkg::cmd_t q_mem_reg [2];

    logic          keep;
    logic          accept;
    logic          push;
    lic_pkg::cmd_t cmd;

    // classify: drop unused codes and loads aimed past the last stage
    always_comb
    begin
        keep           = 1'b0;
        cmd.kind       = lic_pkg::CMD_SAMPLE;
        cmd.sample     = in_word.sample;
        cmd.coef_stage = in_word.coef_stage;
        cmd.coef_value = in_word.coef_value;
        unique case (in_word.action)
            lic_pkg::ACT_SAMPLE:
            begin
                keep     = 1'b1;
                cmd.kind = lic_pkg::CMD_SAMPLE;
            end
            lic_pkg::ACT_LOAD:
            begin
                keep     = (int'(in_word.coef_stage) < STAGES);
                cmd.kind = lic_pkg::CMD_LOAD;
            end
            lic_pkg::ACT_CLEAR:
            begin
                keep     = 1'b1;
                cmd.kind = lic_pkg::CMD_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign accept     = in_valid && !in_stall;
    assign push       = accept && keep;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= cmd;
    end

    `LIC_ASSERT_NOW(a_pop_nonempty, pop, cnt_reg != 2'd0, "pop from empty queue")
    `LIC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= 2'd2, "queue count overflow")
    `LIC_ASSERT_NEXT(a_push_counts, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "push lost")

endmodule

// ===== rtl/core/lic_back.sv =====
`include "leaky_integrator_cascade_macros.svh"

module lic_back #(
    parameter int STAGES = lic_pkg::STAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    input  lic_pkg::head_t     head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output lic_pkg::out_word_t out_word
);

    localparam int IDX_W = $clog2(STAGES);
    localparam int LIMIT = (STAGES < lic_pkg::MAX_REPORT) ? STAGES : lic_pkg::MAX_REPORT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_WB
    } state_t;

    state_t             state_reg;
    logic [4:0]         stages_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic signed [23:0] x_reg;
    logic signed [23:0] old_s_reg;
    logic signed [41:0] prod_reg;
    logic [STAGES-1:0]  state_vld_reg;
    logic [STAGES-1:0]  coef_vld_reg;
    logic               out_valid_reg;
    lic_pkg::out_word_t out_word_reg;

    // stage memories, registered read at idx_reg
    logic signed [23:0] state_mem [STAGES];
    logic [15:0]        coef_mem [STAGES];
    logic signed [23:0] s_rd_reg;
    logic [15:0]        a_rd_reg;
    logic               s_vld_rd_reg;
    logic               a_vld_rd_reg;

    logic [4:0]         k5;
    logic [IDX_W-1:0]   last_calc;
    logic [IDX_W-1:0]   coef_addr;
    logic signed [23:0] s_eff;
    logic [15:0]        a_eff;
    logic signed [24:0] diff;
    logic signed [41:0] prod_next;
    logic signed [41:0] sum;
    logic signed [23:0] result;
    logic               out_free;
    logic               wb_go;
    logic               is_last;

    // clamp stage count to one .. min(STAGES, 16)
    always_comb
    begin
        if (stages_reg == 5'd0)
            k5 = 5'd1;
        else if (int'(stages_reg) > LIMIT)
            k5 = 5'(LIMIT);
        else
            k5 = stages_reg;
    end

    assign last_calc = IDX_W'(k5 - 5'd1);
    assign coef_addr = IDX_W'(head.cmd.coef_stage);

    // new = x + a*(s - x) / 65536, floored
    assign s_eff     = s_vld_rd_reg ? s_rd_reg : 24'sd0;
    assign a_eff     = a_vld_rd_reg ? a_rd_reg : 16'd0;
    assign diff      = 25'(s_eff) - 25'(x_reg);
    assign prod_next = $signed({1'b0, a_eff}) * diff;
    assign sum       = $signed({{2{x_reg[23]}}, x_reg, 16'd0}) + prod_reg;
    assign result    = sum[39:16];

    assign out_free  = !out_valid_reg || !out_stall;
    assign wb_go     = (state_reg == S_WB) && out_free;
    assign is_last   = (idx_reg == last_idx_reg);
    assign pop       = (state_reg == S_IDLE) && head.valid;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stages_reg    <= lic_pkg::CFG_STAGES_RESET;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            x_reg         <= '0;
            old_s_reg     <= '0;
            prod_reg      <= '0;
            state_vld_reg <= '0;
            coef_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                stages_reg <= cfg_data;
            if (out_valid_reg && !out_stall && !wb_go)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        unique case (head.cmd.kind)
                            lic_pkg::CMD_SAMPLE:
                            begin
                                x_reg        <= {head.cmd.sample, 8'd0};
                                idx_reg      <= '0;
                                last_idx_reg <= last_calc;
                                state_reg    <= S_RD;
                            end
                            lic_pkg::CMD_LOAD:
                            begin
                                coef_vld_reg[coef_addr] <= 1'b1;
                            end
                            lic_pkg::CMD_CLEAR:
                            begin
                                state_vld_reg <= '0;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    old_s_reg <= s_eff;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_word_reg.stage_index <= 4'(idx_reg);
                        out_word_reg.stage_value <= result;
                        out_word_reg.last        <= is_last;
                        state_vld_reg[idx_reg]   <= 1'b1;
                        // stage 1 takes the fresh stage 0, higher stages the old predecessor
                        x_reg <= (idx_reg == '0) ? result : old_s_reg;
                        if (is_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        s_rd_reg     <= state_mem[idx_reg];
        a_rd_reg     <= coef_mem[idx_reg];
        s_vld_rd_reg <= state_vld_reg[idx_reg];
        a_vld_rd_reg <= coef_vld_reg[idx_reg];
        if (wb_go)
            state_mem[idx_reg] <= result;
        if (pop && head.cmd.kind == lic_pkg::CMD_LOAD)
            coef_mem[coef_addr] <= head.cmd.coef_value;
    end

    `LIC_ASSERT_NOW(a_idx_bound, state_reg != S_IDLE, idx_reg <= last_idx_reg, "stage index past end")
    `LIC_ASSERT_NEXT(a_last_ends, wb_go && is_last, state_reg == S_IDLE && out_word_reg.last, "last word not closing")
    `LIC_ASSERT_NEXT(a_wb_emits, wb_go, out_valid_reg && out_word_reg.stage_value == $past(result), "result word lost")

endmodule
